@@ design/midi_track_event_parser_top_defines.svh @@
// assertion macros for the midi track event parser
// used by midi_track_event_parser_top, expects clk and arst_n in scope
`ifndef MIDI_TRACK_EVENT_PARSER_TOP_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MTEP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mtep: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define MTEP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mtep: next-cycle check failed");

`endif

@@ design/mtep_pkg.sv @@
// shared types and constants for the midi track event parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mtep_pkg;

	// parse phase, one-hot
	typedef enum logic [5:0] {
		PH_DELTA  = 6'b000001,
		PH_STATUS = 6'b000010,
		PH_META   = 6'b000100,
		PH_LENGTH = 6'b001000,
		PH_DATA   = 6'b010000,
		PH_FAILED = 6'b100000
	} phase_t;

	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_NO_STATUS = 2'd1,
		ERR_UNSUP_SYS = 2'd2,
		ERR_TRUNC     = 2'd3
	} err_t;

	localparam logic [7:0] STATUS_SYSEX = 8'hF0;
	localparam logic [7:0] STATUS_META  = 8'hFF;
	localparam logic [3:0] NIBBLE_PROG  = 4'hC;
	localparam logic [3:0] NIBBLE_PRESS = 4'hD;
	localparam logic [3:0] NIBBLE_SYS   = 4'hF;

	localparam int unsigned TDATA_W = 144;

	typedef struct packed {
		logic [31:0] event_bytes;
		logic [31:0] event_offset;
		logic [31:0] data_length;
		logic [7:0]  meta_type;
		logic [7:0]  status_byte;
		logic [31:0] delta_time;
		err_t        error_code;
		logic        track_end;
	} rec_t;

endpackage

`default_nettype wire

@@ design/midi_track_event_parser_top.sv @@
// Parser for the event stream of a MIDI file track chunk. One chunk byte per
// beat enters on the slave side, tlast marking the final byte of the chunk;
// one record leaves on the master side for each complete event (delta time,
// status, meta type, data length, offset of the status byte and total event
// length), for each bad status byte, and for a chunk that ends inside an
// event or after a failure. Delta times and lengths wrap at 32 bits. After a
// bad status byte the parser drops bytes until the chunk end, which reports
// the stored error. Each byte passes through an input register, one pass
// of decode logic against the parse state and a result register, so a new
// beat is taken each cycle while the result register is free or being
// drained.
// depends on mtep_pkg, mtep_in_stage, mtep_core, mtep_out_stage
`timescale 1ns / 1ps
`default_nettype none
`include "midi_track_event_parser_top_defines.svh"

module midi_track_event_parser_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// slave side: tdata = data_byte[7:0]; tlast = last_byte
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [7:0]                   s_axis_tdata,
	input  wire logic                         s_axis_tlast,
	// master side: tdata = delta_time[31:0], status_byte[39:32], meta_type[47:40],
	// data_length[79:48], event_offset[111:80], event_bytes[143:112]
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	output logic [mtep_pkg::TDATA_W-1:0]      m_axis_tdata,
	// tuser = error_code[1:0]; tlast = track_end
	output logic [1:0]                        m_axis_tuser,
	output logic                              m_axis_tlast
);
	import mtep_pkg::*;

	logic       advance;
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       go;
	logic       rec_valid;
	rec_t       rec;

	// input register, holds one beat while the result side is stalled
	mtep_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.advance       (advance),
		.valid_s1      (valid_s1),
		.data_s1       (data_s1),
		.last_s1       (last_s1)
	);

	// the held byte is consumed whenever the result register can take its outcome
	assign go = valid_s1 && advance;

	// parse state and decode
	mtep_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.data_s1   (data_s1),
		.last_s1   (last_s1),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

	// result register
	mtep_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.go            (go),
		.rec_valid     (rec_valid),
		.rec           (rec),
		.advance       (advance),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// truncation is only ever reported on the chunk end
	`MTEP_ASSERT_IMP(a_trunc_on_end, m_axis_tvalid && m_axis_tuser == ERR_TRUNC, m_axis_tlast)
	// error records carry no event length
	`MTEP_ASSERT_IMP(a_err_no_len, m_axis_tvalid && m_axis_tuser != ERR_OK, m_axis_tdata[143:112] == 32'd0)
	// a held byte that could not move is still held next cycle
	`MTEP_ASSERT_NXT(a_hold_byte, valid_s1 && !advance, valid_s1)

endmodule

`default_nettype wire

@@ design/mtep_in_stage.sv @@
// input register stage of the midi track event parser
// depends on mtep_pkg
`timescale 1ns / 1ps
`default_nettype none

module mtep_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,
	input  wire logic       s_axis_tlast,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      data_s1,
	output logic            last_s1
);
	import mtep_pkg::*;

	logic accept;

	// free when empty or when the held beat moves on this cycle
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

endmodule

`default_nettype wire

@@ design/mtep_core.sv @@
// parse state and per-byte decode of the midi track event parser
// depends on mtep_pkg
`timescale 1ns / 1ps
`default_nettype none

module mtep_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         go,
	input  wire logic [7:0]   data_s1,
	input  wire logic         last_s1,
	output logic              rec_valid,
	output mtep_pkg::rec_t    rec
);
	import mtep_pkg::*;

	phase_t      phase_q, phase_n;
	logic [31:0] delta_q, delta_n;
	logic [7:0]  status_q, status_n;
	logic [7:0]  meta_q, meta_n;
	logic [31:0] len_q, len_n;
	logic [31:0] pref_q, pref_n;
	logic [31:0] rem_q, rem_n;
	logic [31:0] pos_q, pos_n;
	logic [31:0] spos_q, spos_n;
	err_t        failed_q, failed_n;
	err_t        err;
	logic        complete;
	logic [31:0] meta_extra;

	always_comb begin
		phase_n    = phase_q;
		delta_n    = delta_q;
		status_n   = status_q;
		meta_n     = meta_q;
		len_n      = len_q;
		pref_n     = pref_q;
		rem_n      = rem_q;
		spos_n     = spos_q;
		failed_n   = failed_q;
		pos_n      = pos_q + 32'd1;
		err        = ERR_OK;
		complete   = 1'b0;
		rec_valid  = 1'b0;
		rec        = '0;
		meta_extra = '0;

		case (phase_q)
			PH_DELTA: begin
				delta_n = {delta_q[24:0], data_s1[6:0]};
				if (!data_s1[7]) phase_n = PH_STATUS;
			end
			PH_STATUS: begin
				spos_n   = pos_q;
				status_n = data_s1;
				if (!data_s1[7]) begin
					err = ERR_NO_STATUS;
				end else if (data_s1 == STATUS_SYSEX) begin
					phase_n = PH_LENGTH;
				end else if (data_s1 == STATUS_META) begin
					phase_n = PH_META;
				end else if (data_s1[7:4] == NIBBLE_SYS) begin
					err = ERR_UNSUP_SYS;
				end else begin
					len_n   = (data_s1[7:4] == NIBBLE_PROG || data_s1[7:4] == NIBBLE_PRESS)
						? 32'd1 : 32'd2;
					rem_n   = len_n;
					phase_n = PH_DATA;
				end
			end
			PH_META: begin
				meta_n  = data_s1;
				phase_n = PH_LENGTH;
			end
			PH_LENGTH: begin
				len_n  = {len_q[24:0], data_s1[6:0]};
				pref_n = pref_q + 32'd1;
				if (!data_s1[7]) begin
					rem_n = len_n;
					if (len_n == 32'd0) complete = 1'b1;
					else                phase_n  = PH_DATA;
				end
			end
			PH_DATA: begin
				rem_n = rem_q - 32'd1;
				if (rem_n == 32'd0) complete = 1'b1;
			end
			default: begin
			end
		endcase

		if (complete) begin
			meta_extra        = {31'd0, status_n == STATUS_META};
			rec_valid         = 1'b1;
			rec.delta_time    = delta_n;
			rec.status_byte   = status_n;
			rec.meta_type     = meta_n;
			rec.data_length   = len_n;
			rec.event_offset  = spos_n;
			rec.event_bytes   = 32'd1 + meta_extra + pref_n + len_n;
			rec.error_code    = ERR_OK;
			rec.track_end     = last_s1;
		end else if (err != ERR_OK) begin
			rec_valid         = 1'b1;
			rec.delta_time    = delta_n;
			rec.status_byte   = status_n;
			rec.event_offset  = spos_n;
			rec.error_code    = err;
			rec.track_end     = last_s1;
			failed_n          = err;
		end else if (last_s1) begin
			rec_valid         = 1'b1;
			rec.track_end     = 1'b1;
			if (phase_q == PH_FAILED) begin
				rec.event_offset = pos_q;
				rec.error_code   = failed_q;
			end else begin
				rec.delta_time   = delta_n;
				rec.status_byte  = status_n;
				rec.meta_type    = meta_n;
				rec.event_offset = (phase_q == PH_DELTA) ? pos_q : spos_n;
				rec.error_code   = ERR_TRUNC;
			end
		end

		// event done: start over on the next delta; failed: drop bytes until the chunk end
		if (complete || err != ERR_OK) begin
			phase_n  = (err != ERR_OK) ? PH_FAILED : PH_DELTA;
			delta_n  = '0;
			status_n = '0;
			meta_n   = '0;
			len_n    = '0;
			pref_n   = '0;
			rem_n    = '0;
		end

		// chunk end returns everything to reset
		if (last_s1) begin
			phase_n  = PH_DELTA;
			delta_n  = '0;
			status_n = '0;
			meta_n   = '0;
			len_n    = '0;
			pref_n   = '0;
			rem_n    = '0;
			pos_n    = '0;
			spos_n   = '0;
			failed_n = ERR_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_DELTA;
			delta_q  <= '0;
			status_q <= '0;
			meta_q   <= '0;
			len_q    <= '0;
			pref_q   <= '0;
			rem_q    <= '0;
			pos_q    <= '0;
			spos_q   <= '0;
			failed_q <= ERR_OK;
		end else if (go) begin
			phase_q  <= phase_n;
			delta_q  <= delta_n;
			status_q <= status_n;
			meta_q   <= meta_n;
			len_q    <= len_n;
			pref_q   <= pref_n;
			rem_q    <= rem_n;
			pos_q    <= pos_n;
			spos_q   <= spos_n;
			failed_q <= failed_n;
		end
	end

endmodule

`default_nettype wire

@@ design/mtep_out_stage.sv @@
// result register of the midi track event parser
// depends on mtep_pkg
`timescale 1ns / 1ps
`default_nettype none

module mtep_out_stage (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             go,
	input  wire logic                             rec_valid,
	input  wire mtep_pkg::rec_t                   rec,
	output logic                                  advance,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic [mtep_pkg::TDATA_W-1:0]          m_axis_tdata,
	output logic [1:0]                            m_axis_tuser,
	output logic                                  m_axis_tlast
);
	import mtep_pkg::*;

	rec_t rec_q;

	// the register may be refilled when empty or being drained
	assign advance = !m_axis_tvalid || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (advance) begin
			m_axis_tvalid <= go && rec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && go && rec_valid) rec_q <= rec;
	end

	assign m_axis_tdata = {rec_q.event_bytes, rec_q.event_offset, rec_q.data_length,
		rec_q.meta_type, rec_q.status_byte, rec_q.delta_time};
	assign m_axis_tuser = rec_q.error_code;
	assign m_axis_tlast = rec_q.track_end;

endmodule

`default_nettype wire

@@ tb/tb_midi_track_event_parser_top.sv @@
// self-checking testbench for midi_track_event_parser_top: byte stream in, event records out
// holds its own event predictor in a small scoreboard class; depends on mtep_pkg and the dut
`timescale 1ns / 1ps

module tb_midi_track_event_parser_top;
	import mtep_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned TAIL_CYCLES = 8;
	localparam int unsigned RANDOM_BYTES = 170;

	// scoreboard: walks the parse state per accepted byte and keeps the records it implies
	class event_record_board;
		phase_t      parse_phase;
		bit [31:0]   delta_acc;
		bit [31:0]   length_acc;
		bit [31:0]   prefix_count;
		bit [31:0]   payload_left;
		bit [31:0]   byte_offset;
		bit [31:0]   status_offset;
		bit [7:0]    status_seen;
		bit [7:0]    meta_seen;
		err_t        sticky_error;
		rec_t        pending_records[$];
		int unsigned fault_count;

		function new();
			fault_count = 0;
			restart_chunk();
		endfunction

		function void clear_event();
			parse_phase = PH_DELTA;
			delta_acc = '0;
			length_acc = '0;
			prefix_count = '0;
			payload_left = '0;
			status_seen = '0;
			meta_seen = '0;
		endfunction

		function void restart_chunk();
			clear_event();
			byte_offset = '0;
			status_offset = '0;
			sticky_error = ERR_OK;
		endfunction

		function int unsigned pending();
			return pending_records.size();
		endfunction

		// advance the parser by one chunk byte and queue the record it produces, if any
		function void predict_from_byte(bit [7:0] b, bit last_b);
			rec_t      rec;
			bit [31:0] here;
			phase_t    was_phase;
			err_t      fault;
			bit        done;

			here = byte_offset;
			was_phase = parse_phase;
			fault = ERR_OK;
			done = 1'b0;
			rec = '0;
			byte_offset = byte_offset + 32'd1;

			case (parse_phase)
				PH_DELTA: begin
					delta_acc = (delta_acc << 7) + {25'd0, b[6:0]};
					if (!b[7])
						parse_phase = PH_STATUS;
				end
				PH_STATUS: begin
					status_offset = here;
					status_seen = b;
					if (!b[7]) begin
						fault = ERR_NO_STATUS;
					end else if (b == STATUS_SYSEX) begin
						parse_phase = PH_LENGTH;
					end else if (b == STATUS_META) begin
						parse_phase = PH_META;
					end else if (b[7:4] == NIBBLE_SYS) begin
						fault = ERR_UNSUP_SYS;
					end else begin
						length_acc = (b[7:4] == NIBBLE_PROG || b[7:4] == NIBBLE_PRESS) ? 32'd1 : 32'd2;
						payload_left = length_acc;
						parse_phase = PH_DATA;
					end
				end
				PH_META: begin
					meta_seen = b;
					parse_phase = PH_LENGTH;
				end
				PH_LENGTH: begin
					length_acc = (length_acc << 7) + {25'd0, b[6:0]};
					prefix_count = prefix_count + 32'd1;
					if (!b[7]) begin
						payload_left = length_acc;
						if (payload_left == 32'd0)
							done = 1'b1;
						else
							parse_phase = PH_DATA;
					end
				end
				PH_DATA: begin
					payload_left = payload_left - 32'd1;
					if (payload_left == 32'd0)
						done = 1'b1;
				end
				default: begin
				end
			endcase

			if (done) begin
				rec.delta_time = delta_acc;
				rec.status_byte = status_seen;
				rec.meta_type = meta_seen;
				rec.data_length = length_acc;
				rec.event_offset = status_offset;
				rec.event_bytes = 32'd1 + ((status_seen == STATUS_META) ? 32'd1 : 32'd0)
					+ prefix_count + length_acc;
				rec.error_code = ERR_OK;
				rec.track_end = last_b;
				pending_records.push_back(rec);
				clear_event();
			end else if (fault != ERR_OK) begin
				rec.delta_time = delta_acc;
				rec.status_byte = status_seen;
				rec.event_offset = status_offset;
				rec.error_code = fault;
				rec.track_end = last_b;
				pending_records.push_back(rec);
				clear_event();
				sticky_error = fault;
				parse_phase = PH_FAILED;
			end else if (last_b) begin
				if (was_phase == PH_FAILED) begin
					rec.event_offset = here;
					rec.error_code = sticky_error;
				end else begin
					rec.delta_time = delta_acc;
					rec.status_byte = status_seen;
					rec.meta_type = meta_seen;
					rec.event_offset = (was_phase == PH_DELTA) ? here : status_offset;
					rec.error_code = ERR_TRUNC;
				end
				rec.track_end = 1'b1;
				pending_records.push_back(rec);
			end

			if (last_b)
				restart_chunk();
		endfunction

		function void compare_field(string name, bit [31:0] want, logic [31:0] seen);
			if (want !== seen) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
				fault_count++;
			end
		endfunction

		function void check_event_record(rec_t got);
			rec_t want;
			if (pending_records.size() == 0) begin
				$error("record with nothing expected: offset 0x%0h", got.event_offset);
				fault_count++;
				return;
			end
			want = pending_records.pop_front();
			compare_field("delta_time", want.delta_time, got.delta_time);
			compare_field("status_byte", want.status_byte, got.status_byte);
			compare_field("meta_type", want.meta_type, got.meta_type);
			compare_field("data_length", want.data_length, got.data_length);
			compare_field("event_offset", want.event_offset, got.event_offset);
			compare_field("event_bytes", want.event_bytes, got.event_bytes);
			compare_field("error_code", want.error_code, got.error_code);
			compare_field("track_end", want.track_end, got.track_end);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// slave side: one chunk byte per beat, tlast on the final byte of the chunk
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'h00;
	logic         s_axis_tlast = 1'b0;

	// master side: one event record per beat
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]   m_axis_tdata;
	logic [1:0]           m_axis_tuser;
	logic                 m_axis_tlast;

	event_record_board records = new();

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned bytes_sent = 0;
	int unsigned cycle_count = 0;

	midi_track_event_parser_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// receiver back-pressure, redrawn every cycle from the current stall rate
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// every accepted byte goes straight into the predictor
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			records.predict_from_byte(s_axis_tdata, s_axis_tlast);
	end

	// every accepted record is unpacked and checked against the oldest expectation
	always @(posedge clk) begin
		rec_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.delta_time   = m_axis_tdata[31:0];
			got.status_byte  = m_axis_tdata[39:32];
			got.meta_type    = m_axis_tdata[47:40];
			got.data_length  = m_axis_tdata[79:48];
			got.event_offset = m_axis_tdata[111:80];
			got.event_bytes  = m_axis_tdata[143:112];
			got.error_code   = err_t'(m_axis_tuser);
			got.track_end    = m_axis_tlast;
			records.check_event_record(got);
		end
	end

	// watchdog against a hung handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// one beat, with a random hold-off in front of it at the current idle rate
	task automatic send_beat(input bit [7:0] b, input bit last_b);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= last_b;
		do
			@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready));
		bytes_sent++;
	endtask

	task automatic send_chunk(input bit [7:0] chunk[$]);
		foreach (chunk[i])
			send_beat(chunk[i], i == chunk.size() - 1);
	endtask

	// stop sending and hold off until every outstanding record has been seen
	task automatic drain_records();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (records.pending() != 0)
			@(posedge clk);
	endtask

	// variable-length delta: mostly one byte, sometimes long enough to wrap past 32 bits
	function automatic void push_delta(ref bit [7:0] q[$]);
		int unsigned n;
		n = ($urandom_range(99) < 70) ? 1 : $urandom_range(2, 6);
		for (int i = 0; i < n - 1; i++)
			q.push_back({1'b1, 7'($urandom)});
		q.push_back({1'b0, 7'($urandom)});
	endfunction

	// length field that decodes to a small payload: plain, padded with empty
	// continuation bytes, or five bytes whose top bits wrap out of the accumulator
	function automatic int unsigned push_length(ref bit [7:0] q[$]);
		int unsigned value;
		int unsigned form;
		value = ($urandom_range(99) < 85) ? $urandom_range(0, 6) : $urandom_range(7, 40);
		form = $urandom_range(9);
		if (form == 9) begin
			q.push_back({1'b1, 3'($urandom), 4'h0});
			repeat (3) q.push_back(8'h80);
		end else if (form >= 7) begin
			repeat ($urandom_range(1, 2)) q.push_back(8'h80);
		end
		q.push_back({1'b0, value[6:0]});
		return value;
	endfunction

	// one event with random content; broken is set when its status byte is bad
	function automatic void push_event(ref bit [7:0] q[$], output bit broken);
		int unsigned kind;
		int unsigned payload;
		broken = 1'b0;
		push_delta(q);
		kind = $urandom_range(99);
		if (kind < 55) begin
			bit [7:0] st;
			st = 8'($urandom_range(8'h80, 8'hEF));
			q.push_back(st);
			payload = (st[7:4] == NIBBLE_PROG || st[7:4] == NIBBLE_PRESS) ? 1 : 2;
		end else if (kind < 70) begin
			q.push_back(STATUS_SYSEX);
			payload = push_length(q);
		end else if (kind < 92) begin
			q.push_back(STATUS_META);
			q.push_back(8'($urandom));
			payload = push_length(q);
		end else if (kind < 96) begin
			q.push_back({1'b0, 7'($urandom)});
			payload = 0;
			broken = 1'b1;
		end else begin
			q.push_back(8'($urandom_range(8'hF1, 8'hFE)));
			payload = 0;
			broken = 1'b1;
		end
		repeat (payload) q.push_back(8'($urandom));
	endfunction

	// a chunk of a few events; after a bad status some junk follows, and now and
	// then the chunk is cut short somewhere inside
	function automatic void build_chunk(ref bit [7:0] q[$]);
		bit broken;
		int unsigned n_events;
		q.delete();
		n_events = $urandom_range(1, 4);
		for (int i = 0; i < n_events; i++) begin
			push_event(q, broken);
			if (broken) begin
				repeat ($urandom_range(0, 4)) q.push_back(8'($urandom));
				break;
			end
		end
		if ($urandom_range(99) < 15 && q.size() > 1)
			q = q[0:$urandom_range(0, q.size() - 2)];
	endfunction

	initial begin
		bit [7:0] chunk[$];
		int unsigned target;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// program change, meta end-of-track after a two-byte delta, empty sysex on the last byte
		chunk = '{8'h00, 8'hC5, 8'h12, 8'h81, 8'h00, 8'hFF, 8'h2F, 8'h00,
			8'h7F, 8'hF0, 8'h00};
		send_chunk(chunk);
		// delta wrapping past 32 bits, highest channel status, then a chunk end inside a delta
		chunk = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hEF, 8'h00, 8'hFF, 8'h83};
		send_chunk(chunk);
		// missing status bit, bytes dropped until the chunk end reports it
		chunk = '{8'h00, 8'h45, 8'h11, 8'h22};
		send_chunk(chunk);
		// unsupported system status arriving as the final byte
		chunk = '{8'h00, 8'hF8};
		send_chunk(chunk);
		drain_records();

		// random chunks under four pacing regimes, draining between them
		target = bytes_sent;
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 85;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 85;
				end
				default: begin
					idle_pct = 13;
					stall_pct = 13;
				end
			endcase
			target += RANDOM_BYTES;
			while (bytes_sent < target) begin
				build_chunk(chunk);
				send_chunk(chunk);
			end
			drain_records();
		end

		stall_pct = 0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (records.fault_count == 0 && records.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
